// File: rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
// Holds status codes, operation codes, controller states and the command
// and flag structs between controller and datapath. No dependencies.
package skt_pkg;

  localparam int DepthDefault = 16;
  localparam int KeyWidth     = 32;
  localparam int OpWidth      = 2;
  localparam int CapWidth     = 5;
  localparam int PosWidth     = 4;
  localparam int TotalWidth   = 5;

  localparam logic [CapWidth-1:0] CapResetValue = 5'd16;

  // Operation codes; any other code behaves as a lookup
  localparam logic [OpWidth-1:0] OpLookup = 2'd0;
  localparam logic [OpWidth-1:0] OpInsert = 2'd1;
  localparam logic [OpWidth-1:0] OpDelete = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_DECIDE,
    S_UP_READ,
    S_UP_WRITE,
    S_DN_READ,
    S_DN_WRITE,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_READ_MID,
    CMD_COMPARE,
    CMD_SET_MISS,
    CMD_FINISH,
    CMD_INS_START,
    CMD_UP_READ,
    CMD_UP_WRITE,
    CMD_INS_PLACE,
    CMD_DEL_START,
    CMD_DN_READ,
    CMD_DN_WRITE
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e cmd;
    status_e st;
  } dp_ctrl_t;

  typedef struct packed {
    logic [OpWidth-1:0] op;
    logic               lo_lt_hi;
    logic               key_eq;
    logic               found;
    logic               full;
    logic               j_above;
    logic               j_below;
  } dp_flags_t;

endpackage

// File: rtl/sorted_key_table.sv
// Sorted key table: up to DEPTH signed keys kept in ascending order.
// Input beat: start with op_i and search_key_i, taken when busy is low.
// Output beat: result_valid_o is high for one cycle with status_o,
// position_o and entry_total_o; the receiver cannot hold it off.
// Configuration: cfg_we_i writes cfg_data_i into the capacity register;
// write only while busy is low.
// Sequence: a binary search of at most clog2(DEPTH+1) probes, then a
// decision; an insert then shifts every entry above the insert point up
// by one and places the key, and a delete shifts every entry above the
// removed one down by one. Each probe passes through a read and a compare
// state, and each shift step through a read and a write state, for the
// registered read port of the single key memory; a new beat is taken in
// the cycle after the result.
// Reset empties the table and sets the capacity to 16; the key memory is
// not cleared, since entries beyond the count are never used.
module sorted_key_table #(
  parameter int DEPTH = skt_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [skt_pkg::OpWidth-1:0]         op_i,
  input  logic signed [skt_pkg::KeyWidth-1:0] search_key_i,
  input  logic                                cfg_we_i,
  input  logic [skt_pkg::CapWidth-1:0]        cfg_data_i,
  output logic                                result_valid_o,
  output logic [1:0]                          status_o,
  output logic [skt_pkg::PosWidth-1:0]        position_o,
  output logic [skt_pkg::TotalWidth-1:0]      entry_total_o
);

  skt_pkg::dp_ctrl_t  ctrl;
  skt_pkg::dp_flags_t flags;

  skt_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .flags_i        (flags),
    .ctrl_o         (ctrl)
  );

  skt_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .flags_o       (flags),
    .op_i          (op_i),
    .search_key_i  (search_key_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .status_o      (status_o),
    .position_o    (position_o),
    .entry_total_o (entry_total_o)
  );

endmodule

// File: rtl/skt_datapath.sv
// Datapath of the sorted key table: key memory, search bounds, shift
// counter, entry count, capacity register and result registers.
// Depends on skt_pkg; driven by skt_controller commands.
module skt_datapath #(
  parameter int DEPTH = skt_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  skt_pkg::dp_ctrl_t                   ctrl_i,
  output skt_pkg::dp_flags_t                  flags_o,
  input  logic [skt_pkg::OpWidth-1:0]         op_i,
  input  logic signed [skt_pkg::KeyWidth-1:0] search_key_i,
  input  logic                                cfg_we_i,
  input  logic [skt_pkg::CapWidth-1:0]        cfg_data_i,
  output logic [1:0]                          status_o,
  output logic [skt_pkg::PosWidth-1:0]        position_o,
  output logic [skt_pkg::TotalWidth-1:0]      entry_total_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [skt_pkg::KeyWidth-1:0] mem_q [DEPTH];
  logic signed [skt_pkg::KeyWidth-1:0] rdata_q;
  logic signed [skt_pkg::KeyWidth-1:0] key_q;
  logic signed [skt_pkg::KeyWidth-1:0] wdata;
  logic [skt_pkg::OpWidth-1:0]         op_q;
  logic [CW-1:0]                       lo_q, hi_q, mid_q, mid_d;
  logic [CW-1:0]                       where_q, j_q, count_q;
  logic [CW-1:0]                       j_dec, j_inc, raddr, waddr;
  logic                                found_q, mem_we;
  logic [skt_pkg::CapWidth-1:0]        cap_q;
  logic [1:0]                          status_q;
  logic [skt_pkg::PosWidth-1:0]        pos_q;
  logic [31:0]                         where_w, count_w, cap_w, cap_eff;

  assign mid_d   = lo_q + ((hi_q - lo_q) >> 1);
  assign j_dec   = j_q - CW'(1);
  assign j_inc   = j_q + CW'(1);
  assign where_w = 32'(where_q);
  assign count_w = 32'(count_q);
  assign cap_w   = 32'(cap_q);
  assign cap_eff = (cap_w < 32'(DEPTH)) ? cap_w : 32'(DEPTH);

  always_comb begin
    raddr  = mid_d;
    waddr  = j_q;
    wdata  = rdata_q;
    mem_we = 1'b0;
    case (ctrl_i.cmd)
      skt_pkg::CMD_UP_READ:  raddr = j_dec;
      skt_pkg::CMD_DN_READ:  raddr = j_inc;
      skt_pkg::CMD_UP_WRITE: mem_we = 1'b1;
      skt_pkg::CMD_DN_WRITE: mem_we = 1'b1;
      skt_pkg::CMD_INS_PLACE: begin
        mem_we = 1'b1;
        waddr  = where_q;
        wdata  = key_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr[IW-1:0]] <= wdata;
    end
    rdata_q <= mem_q[raddr[IW-1:0]];
  end

  // Search and shift working registers carry no reset
  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      skt_pkg::CMD_LOAD: begin
        op_q    <= op_i;
        key_q   <= search_key_i;
        lo_q    <= '0;
        hi_q    <= count_q;
        found_q <= 1'b0;
      end
      skt_pkg::CMD_READ_MID: mid_q <= mid_d;
      skt_pkg::CMD_COMPARE: begin
        if (rdata_q == key_q) begin
          found_q <= 1'b1;
          where_q <= mid_q;
        end else if (rdata_q < key_q) begin
          lo_q <= mid_q + CW'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      skt_pkg::CMD_SET_MISS: where_q <= lo_q;
      skt_pkg::CMD_INS_START: j_q <= count_q;
      skt_pkg::CMD_UP_WRITE: j_q <= j_dec;
      skt_pkg::CMD_DEL_START: j_q <= where_q;
      skt_pkg::CMD_DN_WRITE: j_q <= j_inc;
      skt_pkg::CMD_INS_PLACE: begin
        status_q <= skt_pkg::ST_OK;
        pos_q    <= where_w[skt_pkg::PosWidth-1:0];
      end
      skt_pkg::CMD_FINISH: begin
        status_q <= ctrl_i.st;
        pos_q    <= (ctrl_i.st == skt_pkg::ST_OK) ? where_w[skt_pkg::PosWidth-1:0] : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= skt_pkg::CapResetValue;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (ctrl_i.cmd == skt_pkg::CMD_INS_PLACE) begin
        count_q <= count_q + CW'(1);
      end else if (ctrl_i.cmd == skt_pkg::CMD_DEL_START) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  assign flags_o.op       = op_q;
  assign flags_o.lo_lt_hi = lo_q < hi_q;
  assign flags_o.key_eq   = rdata_q == key_q;
  assign flags_o.found    = found_q;
  assign flags_o.full     = count_w >= cap_eff;
  assign flags_o.j_above  = j_q > where_q;
  assign flags_o.j_below  = j_q < count_q;

  assign status_o      = status_q;
  assign position_o    = pos_q;
  assign entry_total_o = count_w[skt_pkg::TotalWidth-1:0];

endmodule

// File: rtl/skt_controller.sv
// Controller of the sorted key table: sequences the binary search, the
// decision, the shift passes and the result beat.
// Depends on skt_pkg; steers skt_datapath through command signals.
module skt_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               result_valid_o,
  input  skt_pkg::dp_flags_t flags_i,
  output skt_pkg::dp_ctrl_t  ctrl_o
);

  skt_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctrl_o.cmd     = skt_pkg::CMD_NONE;
    ctrl_o.st      = skt_pkg::ST_OK;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      skt_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl_o.cmd = skt_pkg::CMD_LOAD;
          state_d    = skt_pkg::S_SRCH_ADDR;
        end
      end
      skt_pkg::S_SRCH_ADDR: begin
        if (flags_i.lo_lt_hi) begin
          ctrl_o.cmd = skt_pkg::CMD_READ_MID;
          state_d    = skt_pkg::S_SRCH_CMP;
        end else begin
          ctrl_o.cmd = skt_pkg::CMD_SET_MISS;
          state_d    = skt_pkg::S_DECIDE;
        end
      end
      skt_pkg::S_SRCH_CMP: begin
        ctrl_o.cmd = skt_pkg::CMD_COMPARE;
        state_d    = flags_i.key_eq ? skt_pkg::S_DECIDE : skt_pkg::S_SRCH_ADDR;
      end
      skt_pkg::S_DECIDE: begin
        ctrl_o.cmd = skt_pkg::CMD_FINISH;
        state_d    = skt_pkg::S_DONE;
        case (flags_i.op)
          skt_pkg::OpInsert: begin
            // duplicate takes precedence over full
            if (flags_i.found) begin
              ctrl_o.st = skt_pkg::ST_DUP;
            end else if (flags_i.full) begin
              ctrl_o.st = skt_pkg::ST_FULL;
            end else begin
              ctrl_o.cmd = skt_pkg::CMD_INS_START;
              state_d    = skt_pkg::S_UP_READ;
            end
          end
          skt_pkg::OpDelete: begin
            if (!flags_i.found) begin
              ctrl_o.st = skt_pkg::ST_MISSING;
            end else begin
              ctrl_o.cmd = skt_pkg::CMD_DEL_START;
              state_d    = skt_pkg::S_DN_READ;
            end
          end
          default: begin
            ctrl_o.st = flags_i.found ? skt_pkg::ST_OK : skt_pkg::ST_MISSING;
          end
        endcase
      end
      skt_pkg::S_UP_READ: begin
        if (flags_i.j_above) begin
          ctrl_o.cmd = skt_pkg::CMD_UP_READ;
          state_d    = skt_pkg::S_UP_WRITE;
        end else begin
          ctrl_o.cmd = skt_pkg::CMD_INS_PLACE;
          state_d    = skt_pkg::S_DONE;
        end
      end
      skt_pkg::S_UP_WRITE: begin
        ctrl_o.cmd = skt_pkg::CMD_UP_WRITE;
        state_d    = skt_pkg::S_UP_READ;
      end
      skt_pkg::S_DN_READ: begin
        if (flags_i.j_below) begin
          ctrl_o.cmd = skt_pkg::CMD_DN_READ;
          state_d    = skt_pkg::S_DN_WRITE;
        end else begin
          ctrl_o.cmd = skt_pkg::CMD_FINISH;
          state_d    = skt_pkg::S_DONE;
        end
      end
      skt_pkg::S_DN_WRITE: begin
        ctrl_o.cmd = skt_pkg::CMD_DN_WRITE;
        state_d    = skt_pkg::S_DN_READ;
      end
      skt_pkg::S_DONE: begin
        result_valid_o = 1'b1;
        state_d        = skt_pkg::S_IDLE;
      end
      default: state_d = skt_pkg::S_IDLE;
    endcase
  end

endmodule

// File: test/skt_checker.sv
`timescale 1ns / 1ps
// Checker for the sorted key table: watches command, capacity and result beats,
// keeps its own ordered copy of the keys and compares every result field.
// Depends on skt_pkg for the operation and status codes and the field widths.
module skt_checker #(
  parameter int DEPTH = skt_pkg::DepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [skt_pkg::OpWidth-1:0]         op_i,
  input  logic signed [skt_pkg::KeyWidth-1:0] search_key_i,
  input  logic                                cfg_we_i,
  input  logic [skt_pkg::CapWidth-1:0]        cfg_data_i,
  input  logic                                result_valid_i,
  input  logic [1:0]                          status_i,
  input  logic [skt_pkg::PosWidth-1:0]        position_i,
  input  logic [skt_pkg::TotalWidth-1:0]      entry_total_i,
  output int                                  fail_count_o,
  output int                                  outstanding_o,
  output int                                  checked_o
);

  import skt_pkg::*;

  typedef struct packed {
    status_e                 st;
    logic [PosWidth-1:0]     pos;
    logic [TotalWidth-1:0]   total;
  } reply_t;

  logic signed [KeyWidth-1:0] held_keys [DEPTH];
  int unsigned                key_count;
  logic [CapWidth-1:0]        cap_reg;
  reply_t                     reply_q [$];
  reply_t                     want_r;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on result %0d: %s got %0d expected %0d",
             $realtime, checked_o, what, got, want);
    fail_count_o++;
  endtask

  // Binary search over the held keys; slot gets the hit or the first larger key
  function automatic logic find_slot(input logic signed [KeyWidth-1:0] key,
                                     output int unsigned slot);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = key_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_keys[mid] == key) begin
        slot = mid;
        return 1'b1;
      end
      if (held_keys[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    slot = lo;
    return 1'b0;
  endfunction

  function automatic reply_t apply_command(input logic [OpWidth-1:0] op,
                                           input logic signed [KeyWidth-1:0] key);
    reply_t      r;
    int unsigned slot;
    int unsigned limit;
    logic        hit;
    hit   = find_slot(key, slot);
    r.st  = ST_OK;
    r.pos = '0;
    limit = (cap_reg < DEPTH) ? cap_reg : DEPTH;
    if (op == OpInsert) begin
      // a duplicate wins over a full table
      if (hit) r.st = ST_DUP;
      else if (key_count >= limit) r.st = ST_FULL;
      else begin
        for (int j = key_count; j > slot; j--) held_keys[j] = held_keys[j-1];
        held_keys[slot] = key;
        key_count++;
        r.pos = PosWidth'(slot);
      end
    end else if (op == OpDelete) begin
      if (!hit) r.st = ST_MISSING;
      else begin
        key_count--;
        for (int j = slot; j < key_count; j++) held_keys[j] = held_keys[j+1];
        r.pos = PosWidth'(slot);
      end
    end else if (hit) begin
      r.pos = PosWidth'(slot);
    end else begin
      r.st = ST_MISSING;
    end
    r.total = TotalWidth'(key_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count     = 0;
      cap_reg       = CapResetValue;
      reply_q.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
      checked_o     = 0;
    end else begin
      // retire the result first: it belongs to an earlier beat
      if (result_valid_i) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with nothing expected, status", status_i, -1);
        end else begin
          want_r = reply_q.pop_front();
          if (status_e'(status_i) != want_r.st)
            report_mismatch("status", status_i, want_r.st);
          if (position_i != want_r.pos)
            report_mismatch("position", position_i, want_r.pos);
          if (entry_total_i != want_r.total)
            report_mismatch("entry_total", entry_total_i, want_r.total);
        end
        checked_o++;
      end
      if (cfg_we_i) cap_reg = cfg_data_i;
      if (start_i && !busy_i) reply_q.push_back(apply_command(op_i, search_key_i));
      outstanding_o = reply_q.size();
    end
  end

endmodule

// File: test/tb_sorted_key_table.sv
`timescale 1ns / 1ps
// Top of the sorted key table testbench: clock, reset, command and capacity
// stimulus, watchdog and verdict. Depends on skt_pkg, sorted_key_table, skt_checker.
module tb_sorted_key_table;

  import skt_pkg::*;

  localparam int DEPTH         = 16;
  localparam int PoolSize      = 24;
  localparam int PhaseBeats    = 64;
  localparam int NumPhases     = 8;
  localparam int MaxGap        = 20;
  localparam int DrainCycles   = 60;
  localparam int WatchdogLimit = 2000;

  localparam logic [OpWidth-1:0] OpSpare = 2'd3;
  localparam logic signed [KeyWidth-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [KeyWidth-1:0] KeyMax = 32'sh7FFF_FFFF;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        start        = 1'b0;
  logic [OpWidth-1:0]          op_i         = '0;
  logic signed [KeyWidth-1:0]  search_key_i = '0;
  logic                        cfg_we_i     = 1'b0;
  logic [CapWidth-1:0]         cfg_data_i   = '0;
  logic                        busy;
  logic                        result_valid_o;
  logic [1:0]                  status_o;
  logic [PosWidth-1:0]         position_o;
  logic [TotalWidth-1:0]       entry_total_o;

  int fail_count;
  int outstanding;
  int checked;
  int idle_cycles = 0;
  int op_seen [4];
  int cap_writes = 0;
  logic signed [KeyWidth-1:0] key_pool [PoolSize];

  int          cap_plan [NumPhases] = '{31, 16, 5, 1, 0, 12, 16, 31};
  int          ins_plan [NumPhases] = '{60, 50, 45, 50, 40, 30, 65, 35};
  int          gap_plan [4]         = '{0, 65, 0, 23};

  always #4 clk_i = ~clk_i;

  sorted_key_table #(.DEPTH(DEPTH)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (op_i),
    .search_key_i   (search_key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .position_o     (position_o),
    .entry_total_o  (entry_total_o)
  );

  skt_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .op_i           (op_i),
    .search_key_i   (search_key_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_i (result_valid_o),
    .status_i       (status_o),
    .position_i     (position_o),
    .entry_total_i  (entry_total_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .checked_o      (checked)
  );

  // End the run if no beat of any kind moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, outstanding);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present a command and hold it until taken; returns at the accepting edge
  task automatic send_beat(input logic [OpWidth-1:0] op, input logic signed [KeyWidth-1:0] key);
    start        <= 1'b1;
    op_i         <= op;
    search_key_i <= key;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    op_seen[op]++;
  endtask

  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start        <= 1'b0;
      op_i         <= OpWidth'($urandom);
      search_key_i <= $urandom;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
    end
  endtask

  // Write the capacity only once every result is in and the block is idle
  task automatic write_capacity(input logic [CapWidth-1:0] value);
    start <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0 || busy);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_writes++;
  endtask

  function automatic logic signed [KeyWidth-1:0] pick_key();
    if ($urandom_range(99) < 15) return $urandom;
    return key_pool[$urandom_range(PoolSize - 1)];
  endfunction

  function automatic logic [OpWidth-1:0] pick_op(input int ins_pct);
    int r;
    r = $urandom_range(99);
    if (r < ins_pct) return OpInsert;
    if (r < ins_pct + (95 - ins_pct) / 2) return OpDelete;
    if (r < 95) return OpLookup;
    return OpSpare;
  endfunction

  initial begin
    foreach (op_seen[i]) op_seen[i] = 0;
    key_pool[0] = KeyMin;
    key_pool[1] = KeyMax;
    key_pool[2] = 0;
    key_pool[3] = -1;
    for (int i = 4; i < PoolSize; i++) begin
      if (i % 2 == 0) key_pool[i] = $urandom;
      else key_pool[i] = $signed($urandom_range(40)) - 20;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, then the extremes of the key range
    send_beat(OpLookup, 0);
    send_beat(OpDelete, 5);
    send_beat(OpInsert, 0);
    send_beat(OpInsert, KeyMin);
    send_beat(OpInsert, KeyMax);
    send_beat(OpInsert, -1);
    send_beat(OpInsert, 1);
    send_beat(OpInsert, KeyMax);
    send_beat(OpLookup, KeyMin);
    send_beat(OpLookup, KeyMax);
    send_beat(OpLookup, 0);
    send_beat(OpSpare, -1);
    send_beat(OpLookup, 7);
    send_beat(OpDelete, 0);
    send_beat(OpDelete, KeyMax);
    send_beat(OpDelete, 0);

    // zero capacity: full on a new key, duplicate on a held one
    write_capacity(0);
    send_beat(OpInsert, 9);
    send_beat(OpInsert, -1);

    // capacity below the count: keys kept, inserts full until deletes
    write_capacity(2);
    send_beat(OpInsert, 9);
    send_beat(OpDelete, -1);
    send_beat(OpInsert, 9);
    send_beat(OpDelete, KeyMin);
    send_beat(OpInsert, 9);

    for (int p = 0; p < NumPhases; p++) begin
      write_capacity(CapWidth'(cap_plan[p]));
      for (int n = 0; n < PhaseBeats; n++) begin
        send_beat(pick_op(ins_plan[p]), pick_key());
        sender_gap(gap_plan[p % 4]);
      end
    end

    start <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d lookups, %0d inserts, %0d deletes and %0d spare-code beats",
             op_seen[OpLookup], op_seen[OpInsert], op_seen[OpDelete], op_seen[OpSpare]);
    $display("over %0d capacity settings; %0d results checked, %0d mismatches",
             cap_writes, checked, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/skt_pkg.sv
rtl/skt_datapath.sv
rtl/skt_controller.sv
rtl/sorted_key_table.sv
test/skt_checker.sv
test/tb_sorted_key_table.sv
